### hdl/ulk_pkg.sv
// shared types and constants for the utf-8 lowercase key transcoder
`timescale 1ns / 1ps
`default_nettype none

package ulk_pkg;

    // sequence lengths
    localparam logic [2:0] LEN_NONE  = 3'd0;
    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    // code point bounds: smallest per sequence length, largest, and the surrogate range
    localparam logic [20:0] MIN_TWO   = 21'h000080;
    localparam logic [20:0] MIN_THREE = 21'h000800;
    localparam logic [20:0] MIN_FOUR  = 21'h010000;
    localparam logic [20:0] MAX_CP    = 21'h10FFFF;
    localparam logic [20:0] SURR_LO   = 21'h00D800;
    localparam logic [20:0] SURR_HI   = 21'h00DFFF;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // one group of output words caused by one input word
    typedef struct packed {
        logic [3:0][7:0] data;      // slot 0 goes out first
        logic [1:0]      last_idx;  // slot of the final word
        logic            key_end;   // group closes the key
    } ulk_group_t;

endpackage

`default_nettype wire

### hdl/ulk_front.sv
// front end: decodes utf-8, lowercases and builds output groups
`timescale 1ns / 1ps
`default_nettype none

module ulk_front
    import ulk_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_valid,
    input  wire logic [7:0] byte_data,
    input  wire logic       byte_end,
    output logic            byte_ready,
    input  wire logic       queue_full,
    output logic            push,
    output ulk_group_t      push_group
);

    logic [7:0]  pend_reg [3];
    logic [1:0]  pcount_reg, pcount_next;
    logic [2:0]  elen_reg, elen_next;
    logic [20:0] pv_reg, pv_next;

    logic            accept;
    logic            cont;
    logic            open;
    logic [20:0]     v_acc;
    logic [2:0]      total;
    logic            complete;
    logic            cp_ok;
    logic [20:0]     cp_min;
    logic [20:0]     low;
    logic [3:0][7:0] enc;
    logic [2:0]      lead_len;
    logic [20:0]     lead_pv;
    logic [7:0]      emit_byte;
    logic            fresh_emits;
    logic [2:0]      n_out;
    logic [2:0]      n_m1;
    logic            use_enc;
    logic            pend_wen;

    function automatic logic [20:0] lower_cp(input logic [20:0] c);
        logic [20:0] r;
        begin
            r = c;
            if (c >= 21'h41 && c <= 21'h5A)
                r = c + 21'h20;
            else if ((c >= 21'hC0 && c <= 21'hD6) || (c >= 21'hD8 && c <= 21'hDE))
                r = c + 21'h20;
            else if (c >= 21'h391 && c <= 21'h3AB && c != 21'h3A2)
                r = c + 21'h20;
            else if (c >= 21'h400 && c <= 21'h40F)
                r = c + 21'h50;
            else if (c >= 21'h410 && c <= 21'h42F)
                r = c + 21'h20;
            lower_cp = r;
        end
    endfunction

    assign byte_ready = !queue_full;
    assign accept     = byte_valid && byte_ready;

    always_comb
    begin
        cont     = (byte_data[7:6] == 2'b10);
        open     = (pcount_reg != 2'd0);
        v_acc    = {pv_reg[14:0], byte_data[5:0]};
        total    = {1'b0, pcount_reg} + 3'd1;
        complete = (total >= elen_reg);

        // range check of a completed sequence
        unique case (elen_reg)
            LEN_TWO:   cp_min = MIN_TWO;
            LEN_THREE: cp_min = MIN_THREE;
            default:   cp_min = MIN_FOUR;
        endcase
        cp_ok = (v_acc >= cp_min) && (v_acc <= MAX_CP)
             && !((v_acc >= SURR_LO) && (v_acc <= SURR_HI));

        // re-encode the lowered code point, same length as the input
        low = lower_cp(v_acc);
        enc = '0;
        unique case (elen_reg)
            LEN_TWO:
            begin
                enc[0] = {3'b110, low[10:6]};
                enc[1] = {2'b10, low[5:0]};
            end
            LEN_THREE:
            begin
                enc[0] = {4'b1110, low[15:12]};
                enc[1] = {2'b10, low[11:6]};
                enc[2] = {2'b10, low[5:0]};
            end
            LEN_FOUR:
            begin
                enc[0] = {5'b11110, low[20:18]};
                enc[1] = {2'b10, low[17:12]};
                enc[2] = {2'b10, low[11:6]};
                enc[3] = {2'b10, low[5:0]};
            end
            default: enc = '0;
        endcase

        // lead byte classification
        if (byte_data[7:5] == 3'b110)
        begin
            lead_len = LEN_TWO;
            lead_pv  = {16'd0, byte_data[4:0]};
        end
        else if (byte_data[7:4] == 4'b1110)
        begin
            lead_len = LEN_THREE;
            lead_pv  = {17'd0, byte_data[3:0]};
        end
        else if (byte_data[7:3] == 5'b11110)
        begin
            lead_len = LEN_FOUR;
            lead_pv  = {18'd0, byte_data[2:0]};
        end
        else
        begin
            lead_len = LEN_NONE;
            lead_pv  = '0;
        end

        // ascii gets lowercased, any other raw byte goes out as is
        if (byte_data >= 8'h41 && byte_data <= 8'h5A)
            emit_byte = byte_data + 8'h20;
        else
            emit_byte = byte_data;

        fresh_emits = !byte_data[7] || (lead_len == LEN_NONE) || byte_end;

        // defaults: sequence closes
        pcount_next = '0;
        elen_next   = LEN_NONE;
        pv_next     = '0;
        pend_wen    = 1'b0;
        use_enc     = 1'b0;

        if (open && cont)
        begin
            if (complete)
            begin
                if (cp_ok)
                begin
                    use_enc = 1'b1;
                    n_out   = elen_reg;
                end
                else
                    n_out = total;
            end
            else
            begin
                pend_wen = 1'b1;
                if (byte_end)
                    n_out = total;
                else
                begin
                    n_out       = 3'd0;
                    pcount_next = total[1:0];
                    elen_next   = elen_reg;
                    pv_next     = v_acc;
                end
            end
        end
        else
        begin
            // held bytes flush raw, then the byte starts afresh
            n_out = {1'b0, pcount_reg} + (fresh_emits ? 3'd1 : 3'd0);
            if (!fresh_emits)
            begin
                pend_wen    = 1'b1;
                pcount_next = 2'd1;
                elen_next   = lead_len;
                pv_next     = lead_pv;
            end
        end

        n_m1 = n_out - 3'd1;

        if (use_enc)
            push_group.data = enc;
        else
        begin
            push_group.data[0] = (pcount_reg > 2'd0) ? pend_reg[0] : emit_byte;
            push_group.data[1] = (pcount_reg > 2'd1) ? pend_reg[1] : emit_byte;
            push_group.data[2] = (pcount_reg > 2'd2) ? pend_reg[2] : emit_byte;
            push_group.data[3] = emit_byte;
        end
        push_group.last_idx = n_m1[1:0];
        push_group.key_end  = byte_end;
        push                = accept && (n_out != 3'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcount_reg <= '0;
            elen_reg   <= LEN_NONE;
            pv_reg     <= '0;
        end
        else if (accept)
        begin
            pcount_reg <= pcount_next;
            elen_reg   <= elen_next;
            pv_reg     <= pv_next;
        end
    end

    // held bytes: a lead always lands in slot 0, a continuation at the count
    always_ff @(posedge clk)
    begin
        if (accept && pend_wen)
        begin
            if (open && cont)
                pend_reg[pcount_reg] <= byte_data;
            else
                pend_reg[0] <= byte_data;
        end
    end

`ifndef SYNTHESIS
    a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (pcount_reg != 2'd0) |-> ({1'b0, pcount_reg} < elen_reg))
        else $error("held byte count reached sequence length");

    a_idle_is_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (pcount_reg == 2'd0) |-> ((elen_reg == LEN_NONE) && (pv_reg == 21'd0)))
        else $error("sequence state not cleared while no sequence open");

    a_open_len: assert property (@(posedge clk) disable iff (!rst_n)
        (pcount_reg != 2'd0) |-> ((elen_reg == LEN_TWO) || (elen_reg == LEN_THREE)
                                  || (elen_reg == LEN_FOUR)))
        else $error("open sequence with bad length");
`endif

endmodule

`default_nettype wire

### hdl/ulk_queue.sv
// short group queue between decoder front and serializer back
`timescale 1ns / 1ps
`default_nettype none

module ulk_queue
    import ulk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire ulk_group_t  push_group,
    output logic             full,
    output logic             head_valid,
    output ulk_group_t       head_group,
    input  wire logic        pop
);

    ulk_group_t              ent_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg;
    logic [QPTR_W-1:0]       rd_ptr_reg;
    logic [QPTR_W:0]         cnt_reg;
    logic                    do_push;
    logic                    do_pop;

    assign full       = (cnt_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_group = ent_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            ent_reg[wr_ptr_reg] <= push_group;
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("group pushed into a full queue");
`endif

endmodule

`default_nettype wire

### hdl/ulk_back.sv
// back end: sends the words of the head group one per cycle while word_ready is high
`timescale 1ns / 1ps
`default_nettype none

module ulk_back
    import ulk_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire ulk_group_t  head_group,
    output logic             pop,
    output logic             word_valid,
    output logic [7:0]       word_data,
    output logic             word_last,
    output logic             word_key_end,
    input  wire logic        word_ready
);

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       fire;

    assign word_valid   = head_valid;
    assign word_data    = head_group.data[idx_reg];
    assign word_last    = (idx_reg == head_group.last_idx);
    assign word_key_end = word_last && head_group.key_end;
    assign fire         = word_valid && word_ready;
    assign pop          = fire && word_last;
    assign idx_next     = word_last ? 2'd0 : idx_reg + 2'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else if (fire)
            idx_reg <= idx_next;
    end

`ifndef SYNTHESIS
    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid |-> (idx_reg <= head_group.last_idx))
        else $error("word index past end of group");
`endif

endmodule

`default_nettype wire

### hdl/utf8_lowercase_key_transcoder_core.sv
// top level of the utf-8 lowercase search key transcoder
// a word that completes a character is queued as a group and shows on m_axis once that group reaches the head
// throughput: one input word per cycle while each causes at most one output word and m_axis_tready is high
// a four-byte character or a flushed sequence sends up to four words, one per cycle while m_axis_tready is high
// a two-entry group queue lets input run on while the output drains
// reset: rst_n async active low, closes any open sequence and empties the queue
`timescale 1ns / 1ps
`default_nettype none

module utf8_lowercase_key_transcoder_core
    import ulk_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // input stream
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  wire logic       s_axis_tlast,   // string_end
    // output stream
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,   // [7:0] out_byte
    output logic            m_axis_tlast,   // run_last
    output logic            m_axis_tuser    // [0] key_end
);

    // front to queue
    logic       push;
    ulk_group_t push_group;
    logic       queue_full;

    // queue to back
    logic       head_valid;
    ulk_group_t head_group;
    logic       pop;

    // decode, lowercase and re-encode; each accepted word yields zero
    // to four output words packed as one group
    ulk_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (s_axis_tvalid),
        .byte_data  (s_axis_tdata),
        .byte_end   (s_axis_tlast),
        .byte_ready (s_axis_tready),
        .queue_full (queue_full),
        .push       (push),
        .push_group (push_group)
    );

    // groups wait here so the front keeps taking words during a burst
    ulk_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_group (push_group),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_group (head_group),
        .pop        (pop)
    );

    // walk through the head group one word per cycle while m_axis_tready is high
    ulk_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_group   (head_group),
        .pop          (pop),
        .word_valid   (m_axis_tvalid),
        .word_data    (m_axis_tdata),
        .word_last    (m_axis_tlast),
        .word_key_end (m_axis_tuser),
        .word_ready   (m_axis_tready)
    );

endmodule

`default_nettype wire
